/* rtl/osd_pkg.sv */
// ----------------------------------------------------------------------------
// osd_pkg
// Shared types and constants for the operand stack dup unit: mode and status
// codes, the control word of the microprogram and the sequencer state.
// ----------------------------------------------------------------------------
`default_nettype none

package osd_pkg;

    // Input modes
    localparam logic [2:0] MODE_PUSH    = 3'd0;
    localparam logic [2:0] MODE_POP     = 3'd1;
    localparam logic [2:0] MODE_DUP     = 3'd2;
    localparam logic [2:0] MODE_DUP_X1  = 3'd3;
    localparam logic [2:0] MODE_DUP_X2  = 3'd4;
    localparam logic [2:0] MODE_DUP2    = 3'd5;
    localparam logic [2:0] MODE_DUP2_X1 = 3'd6;
    localparam logic [2:0] MODE_DUP2_X2 = 3'd7;

    // Result status codes
    localparam logic [1:0] STATUS_DONE      = 2'd0;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

    // Write data sources: latched slots v1..v4 (v0..v3 here) or the pushed value
    localparam logic [2:0] SRC_V0   = 3'd0;
    localparam logic [2:0] SRC_V1   = 3'd1;
    localparam logic [2:0] SRC_V2   = 3'd2;
    localparam logic [2:0] SRC_V3   = 3'd3;
    localparam logic [2:0] SRC_PUSH = 3'd4;

    // Stack limit after reset
    localparam logic [6:0] LIMIT_RESET = 7'd64;

    // Program counter width and the shared tail routine (read top, emit)
    localparam int         PC_W    = 6;
    localparam logic [5:0] UC_TAIL = 6'd0;

    typedef enum logic [1:0] {
        OP_STEP  = 2'd0,
        OP_CHECK = 2'd1,
        OP_EMIT  = 2'd2
    } op_t;

    typedef enum logic {
        SEQ_IDLE = 1'b0,
        SEQ_RUN  = 1'b1
    } seq_state_t;

    // One microprogram step
    typedef struct packed {
        op_t        op;
        logic [2:0] take;     // slots consumed (check step)
        logic [2:0] give;     // slots produced (check step)
        logic       rd_en;
        logic [1:0] rd_off;   // read slot at depth-1-rd_off
        logic       lat_en;
        logic [1:0] lat_idx;  // latch read data into v[lat_idx]
        logic       wr_en;
        logic [2:0] wr_src;
        logic [2:0] wr_off;   // write slot at base+wr_off
        logic       dep_upd;  // depth <= base + give
        logic       jmp;      // continue at the tail routine
        logic       raw;      // emit v0 even on an empty stack
    } ucode_word_t;

    // Datapath flags seen by the sequencer
    typedef struct packed {
        logic check_fail;
        logic out_free;
    } dp_flags_t;

    // Program entry address per mode
    function automatic logic [5:0] mode_entry(input logic [2:0] mode);
        logic [5:0] addr;
        case (mode)
            MODE_PUSH:    addr = 6'd3;
            MODE_POP:     addr = 6'd5;
            MODE_DUP:     addr = 6'd9;
            MODE_DUP_X1:  addr = 6'd14;
            MODE_DUP_X2:  addr = 6'd21;
            MODE_DUP2:    addr = 6'd30;
            MODE_DUP2_X1: addr = 6'd38;
            MODE_DUP2_X2: addr = 6'd48;
            default:      addr = UC_TAIL;
        endcase
        return addr;
    endfunction

endpackage

`default_nettype wire

/* rtl/osd_ucode_rom.sv */
// ----------------------------------------------------------------------------
// osd_ucode_rom
// Read-only microprogram: one control word per step for every mode, plus
// the shared tail that reads the new top slot and emits the result.
// ----------------------------------------------------------------------------
`default_nettype none

module osd_ucode_rom (
    input  wire logic [5:0]          addr,
    output osd_pkg::ucode_word_t     word
);

    function automatic osd_pkg::ucode_word_t uc_rd(input logic [1:0] off);
        osd_pkg::ucode_word_t w;
        w        = '0;
        w.rd_en  = 1'b1;
        w.rd_off = off;
        return w;
    endfunction

    function automatic osd_pkg::ucode_word_t uc_lat(input logic [1:0] idx);
        osd_pkg::ucode_word_t w;
        w         = '0;
        w.lat_en  = 1'b1;
        w.lat_idx = idx;
        return w;
    endfunction

    function automatic osd_pkg::ucode_word_t uc_wr(input logic [2:0] src,
                                                   input logic [2:0] off);
        osd_pkg::ucode_word_t w;
        w        = '0;
        w.wr_en  = 1'b1;
        w.wr_src = src;
        w.wr_off = off;
        return w;
    endfunction

    function automatic osd_pkg::ucode_word_t uc_chk(input logic [2:0] take,
                                                    input logic [2:0] give);
        osd_pkg::ucode_word_t w;
        w      = '0;
        w.op   = osd_pkg::OP_CHECK;
        w.take = take;
        w.give = give;
        return w;
    endfunction

    function automatic osd_pkg::ucode_word_t uc_emit(input logic raw);
        osd_pkg::ucode_word_t w;
        w     = '0;
        w.op  = osd_pkg::OP_EMIT;
        w.raw = raw;
        return w;
    endfunction

    // Last write of a dup or push: commit depth, then run the tail
    function automatic osd_pkg::ucode_word_t uc_fin();
        osd_pkg::ucode_word_t w;
        w         = '0;
        w.dep_upd = 1'b1;
        w.jmp     = 1'b1;
        return w;
    endfunction

    // Jump bit alone, used to strip it from the pop depth step
    function automatic osd_pkg::ucode_word_t uc_jmp_only();
        osd_pkg::ucode_word_t w;
        w     = '0;
        w.jmp = 1'b1;
        return w;
    endfunction

    // Program table
    always_comb
    begin
        case (addr)
            // tail: read top, latch, emit
            6'd0:  word = uc_rd(2'd0);
            6'd1:  word = uc_lat(2'd0);
            6'd2:  word = uc_emit(1'b0);
            // push
            6'd3:  word = uc_chk(3'd0, 3'd1);
            6'd4:  word = osd_pkg::ucode_word_t'(uc_wr(osd_pkg::SRC_PUSH, 3'd0) | uc_fin());
            // pop
            6'd5:  word = uc_chk(3'd1, 3'd0);
            6'd6:  word = uc_rd(2'd0);
            6'd7:  word = osd_pkg::ucode_word_t'(uc_lat(2'd0) | uc_fin() & ~uc_jmp_only());
            6'd8:  word = uc_emit(1'b1);
            // dup
            6'd9:  word = uc_chk(3'd1, 3'd2);
            6'd10: word = uc_rd(2'd0);
            6'd11: word = uc_lat(2'd0);
            6'd12: word = uc_wr(osd_pkg::SRC_V0, 3'd0);
            6'd13: word = osd_pkg::ucode_word_t'(uc_wr(osd_pkg::SRC_V0, 3'd1) | uc_fin());
            // dup_x1
            6'd14: word = uc_chk(3'd2, 3'd3);
            6'd15: word = uc_rd(2'd0);
            6'd16: word = osd_pkg::ucode_word_t'(uc_lat(2'd0) | uc_rd(2'd1));
            6'd17: word = uc_lat(2'd1);
            6'd18: word = uc_wr(osd_pkg::SRC_V0, 3'd0);
            6'd19: word = uc_wr(osd_pkg::SRC_V1, 3'd1);
            6'd20: word = osd_pkg::ucode_word_t'(uc_wr(osd_pkg::SRC_V0, 3'd2) | uc_fin());
            // dup_x2
            6'd21: word = uc_chk(3'd3, 3'd4);
            6'd22: word = uc_rd(2'd0);
            6'd23: word = osd_pkg::ucode_word_t'(uc_lat(2'd0) | uc_rd(2'd1));
            6'd24: word = osd_pkg::ucode_word_t'(uc_lat(2'd1) | uc_rd(2'd2));
            6'd25: word = uc_lat(2'd2);
            6'd26: word = uc_wr(osd_pkg::SRC_V0, 3'd0);
            6'd27: word = uc_wr(osd_pkg::SRC_V2, 3'd1);
            6'd28: word = uc_wr(osd_pkg::SRC_V1, 3'd2);
            6'd29: word = osd_pkg::ucode_word_t'(uc_wr(osd_pkg::SRC_V0, 3'd3) | uc_fin());
            // dup2
            6'd30: word = uc_chk(3'd2, 3'd4);
            6'd31: word = uc_rd(2'd0);
            6'd32: word = osd_pkg::ucode_word_t'(uc_lat(2'd0) | uc_rd(2'd1));
            6'd33: word = uc_lat(2'd1);
            6'd34: word = uc_wr(osd_pkg::SRC_V1, 3'd0);
            6'd35: word = uc_wr(osd_pkg::SRC_V0, 3'd1);
            6'd36: word = uc_wr(osd_pkg::SRC_V1, 3'd2);
            6'd37: word = osd_pkg::ucode_word_t'(uc_wr(osd_pkg::SRC_V0, 3'd3) | uc_fin());
            // dup2_x1
            6'd38: word = uc_chk(3'd3, 3'd5);
            6'd39: word = uc_rd(2'd0);
            6'd40: word = osd_pkg::ucode_word_t'(uc_lat(2'd0) | uc_rd(2'd1));
            6'd41: word = osd_pkg::ucode_word_t'(uc_lat(2'd1) | uc_rd(2'd2));
            6'd42: word = uc_lat(2'd2);
            6'd43: word = uc_wr(osd_pkg::SRC_V1, 3'd0);
            6'd44: word = uc_wr(osd_pkg::SRC_V0, 3'd1);
            6'd45: word = uc_wr(osd_pkg::SRC_V2, 3'd2);
            6'd46: word = uc_wr(osd_pkg::SRC_V1, 3'd3);
            6'd47: word = osd_pkg::ucode_word_t'(uc_wr(osd_pkg::SRC_V0, 3'd4) | uc_fin());
            // dup2_x2
            6'd48: word = uc_chk(3'd4, 3'd6);
            6'd49: word = uc_rd(2'd0);
            6'd50: word = osd_pkg::ucode_word_t'(uc_lat(2'd0) | uc_rd(2'd1));
            6'd51: word = osd_pkg::ucode_word_t'(uc_lat(2'd1) | uc_rd(2'd2));
            6'd52: word = osd_pkg::ucode_word_t'(uc_lat(2'd2) | uc_rd(2'd3));
            6'd53: word = uc_lat(2'd3);
            6'd54: word = uc_wr(osd_pkg::SRC_V1, 3'd0);
            6'd55: word = uc_wr(osd_pkg::SRC_V0, 3'd1);
            6'd56: word = uc_wr(osd_pkg::SRC_V3, 3'd2);
            6'd57: word = uc_wr(osd_pkg::SRC_V2, 3'd3);
            6'd58: word = uc_wr(osd_pkg::SRC_V1, 3'd4);
            6'd59: word = osd_pkg::ucode_word_t'(uc_wr(osd_pkg::SRC_V0, 3'd5) | uc_fin());
            default: word = uc_emit(1'b0);
        endcase
    end

endmodule

`default_nettype wire

/* rtl/osd_sequencer.sv */
// ----------------------------------------------------------------------------
// osd_sequencer
// Step counter over the microprogram: loads the entry address of an accepted
// item's mode, advances one step a cycle, jumps to the tail on a failed
// check or an explicit jump, and holds on emit until the output is free.
// ----------------------------------------------------------------------------
`default_nettype none

module osd_sequencer (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic [2:0]           in_mode,
    output logic                      in_ready,
    input  wire osd_pkg::dp_flags_t   flags,
    output osd_pkg::ucode_word_t      ctl
);

    osd_pkg::seq_state_t  state_reg;
    osd_pkg::seq_state_t  state_next;
    logic [5:0]           pc_reg;
    logic [5:0]           pc_next;
    osd_pkg::ucode_word_t rom_word;

    osd_ucode_rom u_rom (
        .addr (pc_reg),
        .word (rom_word)
    );

    // State and step counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= osd_pkg::SEQ_IDLE;
            pc_reg    <= osd_pkg::UC_TAIL;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

    // Next state and next step
    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        case (state_reg)
            osd_pkg::SEQ_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = osd_pkg::SEQ_RUN;
                    pc_next    = osd_pkg::mode_entry(in_mode);
                end
            end
            osd_pkg::SEQ_RUN:
            begin
                case (rom_word.op)
                    osd_pkg::OP_EMIT:
                    begin
                        if (flags.out_free)
                        begin
                            state_next = osd_pkg::SEQ_IDLE;
                        end
                    end
                    osd_pkg::OP_CHECK:
                    begin
                        pc_next = flags.check_fail ? osd_pkg::UC_TAIL
                                                   : osd_pkg::PC_W'(pc_reg + 6'd1);
                    end
                    default:
                    begin
                        pc_next = rom_word.jmp ? osd_pkg::UC_TAIL
                                               : osd_pkg::PC_W'(pc_reg + 6'd1);
                    end
                endcase
            end
            default:
            begin
                state_next = osd_pkg::SEQ_IDLE;
            end
        endcase
    end

    // Outputs: control word is live only while a program runs
    always_comb
    begin
        in_ready = 1'b0;
        ctl      = '0;
        case (state_reg)
            osd_pkg::SEQ_IDLE: in_ready = 1'b1;
            osd_pkg::SEQ_RUN:  ctl      = rom_word;
            default:           in_ready = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/osd_datapath.sv */
// ----------------------------------------------------------------------------
// osd_datapath
// Slot memory with one write and one registered read port, depth and limit
// registers, the four latched top slots, the bounds check and the result
// register. Every action but the limit and push-value loads follows ctl.
// ----------------------------------------------------------------------------
`default_nettype none

module osd_datapath #(
    parameter int STACK_DEPTH = 64,
    parameter int SLOT_WIDTH  = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [6:0]           cfg_limit,
    input  wire logic                 in_accept,
    input  wire logic [31:0]          push_value,
    input  wire osd_pkg::ucode_word_t ctl,
    output osd_pkg::dp_flags_t        flags,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [1:0]                out_status,
    output logic [31:0]               out_top,
    output logic [6:0]                out_depth
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int CW = ((DW > 7) ? DW : 7) + 1;
    localparam logic [CW-1:0] DEPTH_X = CW'(STACK_DEPTH);

    logic [SLOT_WIDTH-1:0] mem [STACK_DEPTH];
    logic [SLOT_WIDTH-1:0] rdata_reg;
    logic [SLOT_WIDTH-1:0] v_reg [4];
    logic [SLOT_WIDTH-1:0] push_reg;
    logic [DW-1:0]         depth_reg;
    logic [DW-1:0]         base_reg;
    logic [2:0]            give_reg;
    logic [1:0]            status_reg;
    logic [6:0]            limit_reg;

    logic                  out_valid_reg;
    logic [1:0]            out_status_reg;
    logic [31:0]           out_top_reg;
    logic [6:0]            out_depth_reg;

    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic [SLOT_WIDTH-1:0] wr_data;
    logic [CW-1:0]         depth_x;
    logic [CW-1:0]         lim_x;
    logic [CW-1:0]         sum_x;
    logic                  under;
    logic                  over;
    logic                  emit;

    // Addresses relative to the top and to the base of the consumed slots
    assign rd_addr = AW'(depth_reg - DW'(1) - DW'(ctl.rd_off));
    assign wr_addr = AW'(base_reg + DW'(ctl.wr_off));

    always_comb
    begin
        case (ctl.wr_src)
            osd_pkg::SRC_V0:   wr_data = v_reg[0];
            osd_pkg::SRC_V1:   wr_data = v_reg[1];
            osd_pkg::SRC_V2:   wr_data = v_reg[2];
            osd_pkg::SRC_V3:   wr_data = v_reg[3];
            osd_pkg::SRC_PUSH: wr_data = push_reg;
            default:           wr_data = '0;
        endcase
    end

    // Slot memory
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Latched slots and pushed value
    always_ff @(posedge clk)
    begin
        if (ctl.lat_en)
        begin
            v_reg[ctl.lat_idx] <= rdata_reg;
        end
        if (in_accept)
        begin
            push_reg <= SLOT_WIDTH'(push_value);
        end
    end

    // Bounds check: underflow first, overflow only when the stack grows
    assign depth_x = CW'(depth_reg);
    assign lim_x   = (CW'(limit_reg) > DEPTH_X) ? DEPTH_X : CW'(limit_reg);
    assign sum_x   = depth_x - CW'(ctl.take) + CW'(ctl.give);
    assign under   = depth_x < CW'(ctl.take);
    assign over    = (ctl.give > ctl.take) && (sum_x > lim_x);

    assign flags.check_fail = under || over;
    assign flags.out_free   = !out_valid_reg || out_ready;
    assign emit             = (ctl.op == osd_pkg::OP_EMIT) && flags.out_free;

    // Control registers: depth, limit, check results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg  <= '0;
            limit_reg  <= osd_pkg::LIMIT_RESET;
            status_reg <= osd_pkg::STATUS_DONE;
            base_reg   <= '0;
            give_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_limit;
            end
            if (ctl.op == osd_pkg::OP_CHECK)
            begin
                base_reg <= DW'(depth_x - CW'(ctl.take));
                give_reg <= ctl.give;
                if (under)
                begin
                    status_reg <= osd_pkg::STATUS_UNDERFLOW;
                end
                else if (over)
                begin
                    status_reg <= osd_pkg::STATUS_OVERFLOW;
                end
                else
                begin
                    status_reg <= osd_pkg::STATUS_DONE;
                end
            end
            if (ctl.dep_upd)
            begin
                depth_reg <= base_reg + DW'(give_reg);
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_status_reg <= status_reg;
            out_depth_reg  <= 7'(depth_reg);
            if (ctl.raw || (depth_reg != '0))
            begin
                out_top_reg <= 32'(v_reg[0]);
            end
            else
            begin
                out_top_reg <= '0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_top    = out_top_reg;
    assign out_depth  = out_depth_reg;

endmodule

`default_nettype wire

/* rtl/operand_stack_dup_unit.sv */
// ----------------------------------------------------------------------------
// operand_stack_dup_unit
// Operand stack with push, pop and the six dup-family instructions.
// ----------------------------------------------------------------------------
// One item runs at a time. Once it is accepted, a microprogram executes one
// step a cycle, each step using the slot memory's single read or write port;
// it holds on the emit step while the result register is still full. The
// result register frees the input side as soon as the result is loaded, so
// a new item may be accepted while the last result waits. A step that would
// underflow or overflow leaves the stack as it was and reports it in the
// status. The stack limit may be rewritten only while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module operand_stack_dup_unit #(
    parameter int STACK_DEPTH = 64,
    parameter int SLOT_WIDTH  = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration: stack_limit
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [6:0]  cfg_data,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] push_value
    input  wire logic [2:0]  s_tuser,   // [2:0] mode
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [31:0] top_value, [38:32] depth, [39] zero
    output logic [1:0]       m_tuser    // [1:0] status
);

    osd_pkg::ucode_word_t ctl;
    osd_pkg::dp_flags_t   flags;
    logic [31:0]          top_value;
    logic [6:0]           depth;

    assign cfg_ready = 1'b1;

    osd_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_mode  (s_tuser),
        .in_ready (s_tready),
        .flags    (flags),
        .ctl      (ctl)
    );

    osd_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .SLOT_WIDTH  (SLOT_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid),
        .cfg_limit  (cfg_data),
        .in_accept  (s_tvalid && s_tready),
        .push_value (s_tdata),
        .ctl        (ctl),
        .flags      (flags),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_top    (top_value),
        .out_depth  (depth)
    );

    assign m_tdata = {1'b0, depth, top_value};

endmodule

`default_nettype wire

/* sim/operand_stack_dup_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// operand_stack_dup_checker
// Watches the configuration, input and result channels of the operand stack
// dup unit. Every accepted input item is run through a local copy of the
// stack and the limit register. Every accepted result is compared field by
// field with the oldest predicted result.
// ----------------------------------------------------------------------------

module operand_stack_dup_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [6:0]  cfg_data,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] push_value
    input  wire logic [2:0]  s_tuser,   // [2:0] mode
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [39:0] m_tdata,   // [31:0] top_value, [38:32] depth, [39] zero
    input  wire logic [1:0]  m_tuser,   // [1:0] status
    output int               fail_count,
    output int               pending,
    output int               checked,
    output int               underflows,
    output int               overflows
);

    localparam int unsigned STACK_SLOTS = 64;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] top;
        logic [6:0]  depth;
    } stack_result_t;

    // Local copy of the stack
    logic [31:0]   slots [0:STACK_SLOTS-1];
    int unsigned   depth_now = 0;
    int unsigned   limit_reg = osd_pkg::LIMIT_RESET;
    stack_result_t result_fifo [$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
        checked    = 0;
        underflows = 0;
        overflows  = 0;
    end

    // Run one item on the local stack and work out its result
    task automatic run_stack_op(input logic [2:0] mode, input logic [31:0] value,
                                output stack_result_t res);
        int unsigned lim;
        int unsigned take;
        int unsigned give;
        int unsigned base;
        logic [31:0] v0, v1, v2, v3;
        res.status = osd_pkg::STATUS_DONE;
        res.top    = '0;
        lim  = (limit_reg > STACK_SLOTS) ? STACK_SLOTS : limit_reg;
        take = 0;
        give = 0;
        if (mode == osd_pkg::MODE_PUSH)
        begin
            if (depth_now + 1 > lim)
                res.status = osd_pkg::STATUS_OVERFLOW;
            else
            begin
                slots[depth_now] = value;
                depth_now++;
            end
        end
        else if (mode == osd_pkg::MODE_POP)
        begin
            if (depth_now == 0)
                res.status = osd_pkg::STATUS_UNDERFLOW;
            else
            begin
                depth_now--;
                res.top = slots[depth_now];
            end
        end
        else
        begin
            case (mode)
                osd_pkg::MODE_DUP:     begin take = 1; give = 2; end
                osd_pkg::MODE_DUP_X1:  begin take = 2; give = 3; end
                osd_pkg::MODE_DUP_X2:  begin take = 3; give = 4; end
                osd_pkg::MODE_DUP2:    begin take = 2; give = 4; end
                osd_pkg::MODE_DUP2_X1: begin take = 3; give = 5; end
                default:               begin take = 4; give = 6; end
            endcase
            if (depth_now < take)
                res.status = osd_pkg::STATUS_UNDERFLOW;
            else if (depth_now - take + give > lim)
                res.status = osd_pkg::STATUS_OVERFLOW;
            else
            begin
                // v0 is the top slot
                v0 = slots[depth_now - 1];
                v1 = (take > 1) ? slots[depth_now - 2] : '0;
                v2 = (take > 2) ? slots[depth_now - 3] : '0;
                v3 = (take > 3) ? slots[depth_now - 4] : '0;
                base = depth_now - take;
                case (mode)
                    osd_pkg::MODE_DUP:
                    begin
                        slots[base] = v0; slots[base+1] = v0;
                    end
                    osd_pkg::MODE_DUP_X1:
                    begin
                        slots[base] = v0; slots[base+1] = v1; slots[base+2] = v0;
                    end
                    osd_pkg::MODE_DUP_X2:
                    begin
                        slots[base]   = v0; slots[base+1] = v2;
                        slots[base+2] = v1; slots[base+3] = v0;
                    end
                    osd_pkg::MODE_DUP2:
                    begin
                        slots[base]   = v1; slots[base+1] = v0;
                        slots[base+2] = v1; slots[base+3] = v0;
                    end
                    osd_pkg::MODE_DUP2_X1:
                    begin
                        slots[base]   = v1; slots[base+1] = v0; slots[base+2] = v2;
                        slots[base+3] = v1; slots[base+4] = v0;
                    end
                    default:
                    begin
                        slots[base]   = v1; slots[base+1] = v0; slots[base+2] = v3;
                        slots[base+3] = v2; slots[base+4] = v1; slots[base+5] = v0;
                    end
                endcase
                depth_now = base + give;
            end
        end
        // everything but pop reports the top slot, zero on an empty stack
        if (mode != osd_pkg::MODE_POP)
            res.top = (depth_now == 0) ? '0 : slots[depth_now - 1];
        res.depth = depth_now[6:0];
    endtask

    // Track register writes, check results, predict new items
    always @(posedge clk or negedge rst_n)
    begin : watch
        stack_result_t want;
        stack_result_t got;
        if (!rst_n)
        begin
            depth_now = 0;
            limit_reg = osd_pkg::LIMIT_RESET;
            result_fifo.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                limit_reg = cfg_data;

            if (m_tvalid && m_tready)
            begin
                got.status = m_tuser;
                got.top    = m_tdata[31:0];
                got.depth  = m_tdata[38:32];
                if (result_fifo.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: status %0d top %h depth %0d",
                                 got.status, got.top, got.depth);
                end
                else
                begin
                    want = result_fifo.pop_front();
                    checked++;
                    if (got.status !== want.status || got.top !== want.top ||
                        got.depth !== want.depth)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"result %0d mismatch: expected status %0d top %h ",
                                      "depth %0d, got status %0d top %h depth %0d"},
                                     checked, want.status, want.top, want.depth,
                                     got.status, got.top, got.depth);
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                run_stack_op(s_tuser, s_tdata, want);
                if (want.status == osd_pkg::STATUS_UNDERFLOW)
                    underflows++;
                if (want.status == osd_pkg::STATUS_OVERFLOW)
                    overflows++;
                result_fifo.push_back(want);
            end
            pending = result_fifo.size();
        end
    end

endmodule

/* sim/operand_stack_dup_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// operand_stack_dup_unit_tb
// Drives the operand stack dup unit with a directed run over the empty,
// full and lowered-limit cases, then random bursts that fill and drain the
// stack under several stack limits, with random gaps on both channels.
// Checking is done by the checker instance; this module gives the verdict.
// ----------------------------------------------------------------------------

module operand_stack_dup_unit_tb;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 160;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [6:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    int fail_count;
    int pending;
    int checked;
    int underflows;
    int overflows;
    int items_sent    = 0;
    int limits_set    = 0;
    int cycle_count   = 0;
    bit rx_steady     = 1'b1;

    operand_stack_dup_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    operand_stack_dup_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked),
        .underflows (underflows),
        .overflows  (overflows)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("status: fail");
            $finish;
        end
    end

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Result side back-pressure
    initial
    begin : result_sink
        int len;
        m_tready = 1'b0;
        forever
        begin
            len = rx_steady ? 0 : pick_gap();
            if (len > 0)
            begin
                m_tready <= 1'b0;
                repeat (len) @(negedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
    end

    // Offer one item, hold it until accepted, then leave the input idle for the given gap
    task automatic send_item(input logic [2:0] mode, input logic [31:0] value,
                             input int gap);
        s_tuser  <= mode;
        s_tdata  <= value;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Drain all results, then write the stack limit
    task automatic set_stack_limit(input int lim);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        cfg_data  <= lim[6:0];
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        limits_set++;
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        int phase;
        int n;
        int r;
        int lim;
        int gap;
        bit fill_bias;
        bit tx_steady;
        logic [2:0]  mode;
        logic [31:0] value;

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = osd_pkg::MODE_PUSH;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty stack, each dup ordering, extreme values
        send_item(osd_pkg::MODE_POP,     32'h0000_0000, 0);
        send_item(osd_pkg::MODE_DUP,     32'hFFFF_FFFF, 0);
        send_item(osd_pkg::MODE_PUSH,    32'hFFFF_FFFF, 0);
        send_item(osd_pkg::MODE_DUP_X1,  32'h0000_0000, 1);
        send_item(osd_pkg::MODE_DUP,     32'h0000_0000, 0);
        send_item(osd_pkg::MODE_DUP2_X1, 32'h0000_0000, 0);
        send_item(osd_pkg::MODE_PUSH,    32'h0000_0000, 2);
        send_item(osd_pkg::MODE_PUSH,    32'h1234_5678, 0);
        send_item(osd_pkg::MODE_DUP2_X2, 32'h0000_0000, 0);
        send_item(osd_pkg::MODE_DUP_X2,  32'h0000_0000, 0);
        send_item(osd_pkg::MODE_DUP2_X1, 32'h0000_0000, 3);
        send_item(osd_pkg::MODE_DUP2,    32'h0000_0000, 0);
        send_item(osd_pkg::MODE_DUP_X1,  32'h0000_0000, 0);
        send_item(osd_pkg::MODE_POP,     32'hFFFF_FFFF, 0);
        send_item(osd_pkg::MODE_POP,     32'h0000_0000, 0);

        // Limit lowered below the current depth: growth rejected, pop still works
        set_stack_limit(4);
        send_item(osd_pkg::MODE_PUSH,    32'hA5A5_A5A5, 0);
        send_item(osd_pkg::MODE_DUP2,    32'h0000_0000, 0);
        send_item(osd_pkg::MODE_POP,     32'h0000_0000, 0);
        send_item(osd_pkg::MODE_DUP,     32'h0000_0000, 0);
        set_stack_limit(0);
        send_item(osd_pkg::MODE_PUSH,    32'h5A5A_5A5A, 0);
        send_item(osd_pkg::MODE_POP,     32'h0000_0000, 0);

        // Random: bursts that fill or drain the stack, under several limits
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       lim = 64;
                1:       lim = 5;
                2:       lim = 1;
                3:       lim = 63;
                4:       lim = 0;
                5:       lim = 2;
                6:       lim = $urandom_range(0, 64);
                7:       lim = 4;
                8:       lim = 6;
                default: lim = 64;
            endcase
            set_stack_limit(lim);
            fill_bias = 1'b1;
            tx_steady = 1'b0;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 30 == 0)
                begin
                    fill_bias = ($urandom_range(0, 2) != 0) ? ~fill_bias : fill_bias;
                    tx_steady = ($urandom_range(0, 3) == 0);
                    rx_steady = ($urandom_range(0, 3) == 0);
                end
                r = $urandom_range(0, 99);
                if (r < (fill_bias ? 45 : 15))
                    mode = osd_pkg::MODE_PUSH;
                else if (r < (fill_bias ? 60 : 70))
                    mode = osd_pkg::MODE_POP;
                else
                    mode = 3'($urandom_range(osd_pkg::MODE_DUP, osd_pkg::MODE_DUP2_X2));
                r = $urandom_range(0, 9);
                if (r == 0)
                    value = 32'h0000_0000;
                else if (r == 1)
                    value = 32'hFFFF_FFFF;
                else
                    value = $urandom;
                gap = tx_steady ? 0 : pick_gap();
                send_item(mode, value, gap);
            end
        end

        // Wait for the last results to drain
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);

        $display("sent %0d items over %0d stack limit writes, %0d results compared",
                 items_sent, limits_set, checked);
        $display("rejected items seen: %0d underflow, %0d overflow, %0d mismatches",
                 underflows, overflows, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
